// ===== rtl/core/sut_pkg.sv =====
package sut_pkg;

	// Table geometry. The table is split into equal segments, one per cell.
	localparam int DEPTH     = 4096;
	localparam int KEY_WIDTH = 64;
	localparam int NUM_CELLS = 16;

	localparam int IDX_W     = $clog2(DEPTH);
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int CELL_W    = $clog2(NUM_CELLS);
	localparam int SEG_W     = IDX_W - CELL_W;
	localparam int SEG_DEPTH = DEPTH / NUM_CELLS;

	// Fixed port widths.
	localparam int KEY_W    = 64;
	localparam int POS_W    = 13;
	localparam int RIDX_W   = 12;
	localparam int STATUS_W = 3;

	localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - KEY_WIDTH);

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_READ   = 1'b1;

	localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd0;
	localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_READ_OK  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_READ_BAD = 3'd4;

	// Command broadcast from the controller to every cell of the row.
	typedef struct packed {
		logic              rd_all;
		logic              rd_one;
		logic [CELL_W-1:0] rd_cell;
		logic [SEG_W-1:0]  rd_off;
		logic              cap_top;
		logic              wr_valid;
		logic [SEG_W-1:0]  wr_off;
		logic [IDX_W-1:0]  pos;
		logic [CNT_W-1:0]  count;
		logic [KEY_W-1:0]  key;
	} cell_cmd_t;

endpackage

// ===== rtl/core/sut_cell.sv =====
// One segment of the sorted table. During an insert sweep every cell moves its
// entries above the insert position up one, top entry to the next cell's bottom.
module sut_cell (
	input  logic                       clk,
	input  sut_pkg::cell_cmd_t         cmd,
	input  logic [sut_pkg::CELL_W-1:0] cell_index,
	input  logic [sut_pkg::KEY_W-1:0]  prev_top,
	output logic [sut_pkg::KEY_W-1:0]  top,
	output logic [sut_pkg::KEY_W-1:0]  rdata
);

	logic [sut_pkg::KEY_W-1:0] mem_q [sut_pkg::SEG_DEPTH];
	logic [sut_pkg::KEY_W-1:0] rdata_q;
	logic [sut_pkg::KEY_W-1:0] top_q;
	logic [sut_pkg::IDX_W-1:0] gidx;
	logic                      rd_en;
	logic                      at_pos;
	logic                      wr_en;
	logic [sut_pkg::KEY_W-1:0] wdata;

	always_comb begin
		gidx   = {cell_index, cmd.wr_off};
		rd_en  = cmd.rd_all || (cmd.rd_one && (cmd.rd_cell == cell_index));
		at_pos = (gidx == cmd.pos);
		wr_en  = cmd.wr_valid && (at_pos || ((gidx > cmd.pos) &&
			(sut_pkg::CNT_W'(gidx) <= cmd.count)));
		if (at_pos) begin
			wdata = cmd.key;
		end else if (cmd.wr_off == '0) begin
			wdata = prev_top;
		end else begin
			wdata = rdata_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[cmd.wr_off] <= wdata;
		end
		if (rd_en) begin
			rdata_q <= mem_q[cmd.rd_off];
		end
		if (cmd.cap_top) begin
			top_q <= rdata_q;
		end
	end

	assign top   = top_q;
	assign rdata = rdata_q;

endmodule

// ===== rtl/core/sut_ctrl.sv =====
// Sequencer: binary search over the cell row, insert sweep, entry reads, and result registers.
module sut_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         opcode,
	input  logic [sut_pkg::KEY_W-1:0]    key,
	input  logic [sut_pkg::RIDX_W-1:0]   read_index,
	input  logic [sut_pkg::KEY_W-1:0]    cell_rdata [sut_pkg::NUM_CELLS],
	output sut_pkg::cell_cmd_t           cmd,
	output logic                         done,
	output logic [sut_pkg::STATUS_W-1:0] status,
	output logic [sut_pkg::POS_W-1:0]    position,
	output logic [sut_pkg::KEY_W-1:0]    entry_value,
	output logic [sut_pkg::POS_W-1:0]    entry_total
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SRCH   = 3'd1;
	localparam logic [2:0] S_CMP    = 3'd2;
	localparam logic [2:0] S_TOP    = 3'd3;
	localparam logic [2:0] S_SWEEP  = 3'd4;
	localparam logic [2:0] S_FIN    = 3'd5;
	localparam logic [2:0] S_RDWAIT = 3'd6;

	localparam logic [sut_pkg::SEG_W-1:0] SEG_LAST = sut_pkg::SEG_W'(sut_pkg::SEG_DEPTH - 1);
	localparam logic [sut_pkg::CNT_W-1:0] CNT_FULL = sut_pkg::CNT_W'(sut_pkg::DEPTH);

	logic [2:0]                   state_q;
	logic [sut_pkg::CNT_W-1:0]    count_q;
	logic [sut_pkg::SEG_W-1:0]    sweep_q;
	logic                         done_q;
	logic                         wr_valid_s1;
	logic [sut_pkg::SEG_W-1:0]    wr_off_s1;
	logic [sut_pkg::CNT_W-1:0]    lo_q;
	logic [sut_pkg::CNT_W-1:0]    hi_q;
	logic [sut_pkg::CNT_W-1:0]    mid_q;
	logic [sut_pkg::IDX_W-1:0]    pos_q;
	logic [sut_pkg::KEY_W-1:0]    key_q;
	logic [sut_pkg::CELL_W-1:0]   rsel_q;
	logic [sut_pkg::STATUS_W-1:0] status_q;
	logic [sut_pkg::POS_W-1:0]    position_q;
	logic [sut_pkg::KEY_W-1:0]    value_q;
	logic [sut_pkg::POS_W-1:0]    total_q;

	logic [sut_pkg::CNT_W-1:0]    mid;
	logic [sut_pkg::IDX_W-1:0]    mid_idx;
	logic [sut_pkg::IDX_W-1:0]    ridx;
	logic                         search_go;
	logic                         accept;
	logic                         rd_ok;
	logic [sut_pkg::KEY_W-1:0]    probe;

	always_comb begin
		mid       = lo_q + ((hi_q - lo_q) >> 1);
		mid_idx   = mid[sut_pkg::IDX_W-1:0];
		ridx      = sut_pkg::IDX_W'(read_index);
		search_go = (lo_q < hi_q);
		accept    = start && (state_q == S_IDLE);
		rd_ok     = (sut_pkg::CNT_W'(read_index) < count_q);
		probe     = cell_rdata[rsel_q];
	end

	always_comb begin
		cmd.rd_all   = (state_q == S_TOP) || ((state_q == S_SWEEP) && (sweep_q != '0));
		cmd.rd_one   = ((state_q == S_SRCH) && search_go) ||
			(accept && (opcode == sut_pkg::OP_READ) && rd_ok);
		cmd.cap_top  = (state_q == S_SWEEP) && (sweep_q == SEG_LAST);
		cmd.wr_valid = wr_valid_s1;
		cmd.wr_off   = wr_off_s1;
		cmd.pos      = pos_q;
		cmd.count    = count_q;
		cmd.key      = key_q;
		case (state_q)
			S_SRCH: begin
				cmd.rd_cell = mid_idx[sut_pkg::IDX_W-1 -: sut_pkg::CELL_W];
				cmd.rd_off  = mid_idx[sut_pkg::SEG_W-1:0];
			end
			S_TOP: begin
				cmd.rd_cell = '0;
				cmd.rd_off  = SEG_LAST;
			end
			S_SWEEP: begin
				cmd.rd_cell = '0;
				cmd.rd_off  = sweep_q - 1'b1;
			end
			default: begin
				cmd.rd_cell = ridx[sut_pkg::IDX_W-1 -: sut_pkg::CELL_W];
				cmd.rd_off  = ridx[sut_pkg::SEG_W-1:0];
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			sweep_q     <= '0;
			done_q      <= 1'b0;
			wr_valid_s1 <= 1'b0;
		end else begin
			done_q      <= 1'b0;
			wr_valid_s1 <= (state_q == S_SWEEP);
			case (state_q)
				S_IDLE: begin
					if (start) begin
						if (opcode == sut_pkg::OP_INSERT) begin
							state_q <= S_SRCH;
						end else if (rd_ok) begin
							state_q <= S_RDWAIT;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				S_SRCH: begin
					if (search_go) begin
						state_q <= S_CMP;
					end else if (count_q == CNT_FULL) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end else begin
						state_q <= S_TOP;
					end
				end
				S_CMP: begin
					if (probe == key_q) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end else begin
						state_q <= S_SRCH;
					end
				end
				S_TOP: begin
					state_q <= S_SWEEP;
					sweep_q <= SEG_LAST;
				end
				S_SWEEP: begin
					sweep_q <= sweep_q - 1'b1;
					if (sweep_q == '0) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
					count_q <= count_q + 1'b1;
				end
				S_RDWAIT: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath and result registers.
	always_ff @(posedge clk) begin
		wr_off_s1 <= sweep_q;
		if (cmd.rd_one) begin
			rsel_q <= cmd.rd_cell;
		end
		case (state_q)
			S_IDLE: begin
				if (start) begin
					lo_q       <= '0;
					hi_q       <= count_q;
					key_q      <= key & sut_pkg::KEY_MASK;
					position_q <= sut_pkg::POS_W'(read_index);
					status_q   <= sut_pkg::ST_READ_BAD;
					value_q    <= '0;
					total_q    <= sut_pkg::POS_W'(count_q);
				end
			end
			S_SRCH: begin
				mid_q <= mid;
				if (!search_go) begin
					pos_q      <= lo_q[sut_pkg::IDX_W-1:0];
					status_q   <= sut_pkg::ST_FULL;
					position_q <= sut_pkg::POS_W'(lo_q);
					value_q    <= '0;
					total_q    <= sut_pkg::POS_W'(count_q);
				end
			end
			S_CMP: begin
				if (probe == key_q) begin
					status_q   <= sut_pkg::ST_FOUND;
					position_q <= sut_pkg::POS_W'(mid_q);
					value_q    <= key_q;
					total_q    <= sut_pkg::POS_W'(count_q);
				end else if (probe < key_q) begin
					lo_q <= mid_q + 1'b1;
				end else begin
					hi_q <= mid_q;
				end
			end
			S_FIN: begin
				status_q   <= sut_pkg::ST_INSERTED;
				position_q <= sut_pkg::POS_W'(pos_q);
				value_q    <= key_q;
				total_q    <= sut_pkg::POS_W'(count_q + 1'b1);
			end
			S_RDWAIT: begin
				status_q <= sut_pkg::ST_READ_OK;
				value_q  <= probe;
			end
			default: begin
			end
		endcase
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign status      = status_q;
	assign position    = position_q;
	assign entry_value = value_q;
	assign entry_total = total_q;

	// A result is only shown once the sequencer is back at rest.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == S_IDLE))
		else $error("result strobe while sequencer busy");

	// An accepted transaction either starts work or completes at once.
	a_accept_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done_q))
		else $error("accepted transaction was lost");

	// A probe is only compared while the search window is not empty.
	a_cmp_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP) |-> (lo_q < hi_q))
		else $error("compare with empty search window");

	// An insert result always comes with a count that just grew by one.
	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && (status_q == sut_pkg::ST_INSERTED)) |->
		(count_q == sut_pkg::CNT_W'($past(count_q) + 1'b1)))
		else $error("insert result without count increment");

	// The count never passes the table size.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN) |-> (count_q < CNT_FULL))
		else $error("insert sweep into a full table");

endmodule

// ===== rtl/core/sorted_unique_table_insert.sv =====
// Sorted table of distinct 64-bit keys with binary-search insert. A transaction
// is taken at a rising edge with start high and busy low. opcode 0 looks the
// key up and inserts it when absent; opcode 1 reads the entry at read_index.
// Exactly one result follows every transaction: done is high for one cycle
// with status, position, entry_value and entry_total, and the receiver cannot
// stall it, so it must take the result in that cycle. A read whose index lies
// beyond the count answers in the cycle after acceptance; a valid read first
// waits in S_RDWAIT for its registered memory read. An insert runs a binary
// search in which each probe is one registered memory read (S_SRCH) and one
// compare (S_CMP). Inserting an absent key then fetches every cell's top entry
// (S_TOP), sweeps through the depth of one cell's segment and finishes in
// S_FIN. A dropped insert into a full table answers after the search. The
// table starts empty after reset; no clearing pass is needed since only
// entries below the count are ever used.
//
// The table is a row of 16 cells, each with a 256-entry segment memory. During
// the insert sweep all cells step through their segments from the top down in
// lockstep, each moving its entries above the insert position up by one slot,
// while the entry that falls off the top of a cell is handed to the bottom
// slot of the next cell. The cell that holds the insert position writes the
// new key there in the same sweep.
module sorted_unique_table_insert (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         opcode,
	input  logic [sut_pkg::KEY_W-1:0]    key,
	input  logic [sut_pkg::RIDX_W-1:0]   read_index,
	output logic                         done,
	output logic [sut_pkg::STATUS_W-1:0] status,
	output logic [sut_pkg::POS_W-1:0]    position,
	output logic [sut_pkg::KEY_W-1:0]    entry_value,
	output logic [sut_pkg::POS_W-1:0]    entry_total
);

	sut_pkg::cell_cmd_t        cmd;
	logic [sut_pkg::KEY_W-1:0] cell_rdata [sut_pkg::NUM_CELLS];
	logic [sut_pkg::KEY_W-1:0] cell_top   [sut_pkg::NUM_CELLS];
	logic [sut_pkg::KEY_W-1:0] cell_prev  [sut_pkg::NUM_CELLS];

	// The sequencer owns the transaction handshake and the result registers.
	sut_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.opcode      (opcode),
		.key         (key),
		.read_index  (read_index),
		.cell_rdata  (cell_rdata),
		.cmd         (cmd),
		.done        (done),
		.status      (status),
		.position    (position),
		.entry_value (entry_value),
		.entry_total (entry_total)
	);

	// Row of cells. Each cell's top entry feeds the next cell's bottom slot;
	// the first cell never receives one, since nothing can move into index zero.
	for (genvar c = 0; c < sut_pkg::NUM_CELLS; c++) begin : g_cell
		if (c == 0) begin : g_first
			assign cell_prev[c] = '0;
		end else begin : g_rest
			assign cell_prev[c] = cell_top[c-1];
		end

		sut_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.cell_index (sut_pkg::CELL_W'(c)),
			.prev_top   (cell_prev[c]),
			.top        (cell_top[c]),
			.rdata      (cell_rdata[c])
		);
	end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

// Testbench for the sorted table of distinct keys.
//
// Every transaction goes to a behavioral copy of the table at the clock edge
// where it is accepted. That copy does its own binary search and shift, and the
// result it gives is queued. Each done strobe from the block is then compared
// field by field with the oldest queued result.
//
// The stimulus comes in two parts.
// - A directed opening covers the empty table, key zero, the key extremes, a
//   found key and reads both inside and beyond the count.
// - A random middle mixes fresh keys, keys already held, neighbors of held
//   keys, valid reads and reads at any index.
// The sender works in bursts with random gaps between them. While it idles it
// puts random values on the command fields, which the block must ignore.
module tb;

	typedef struct packed {
		logic                         opcode;
		logic [sut_pkg::KEY_W-1:0]    key;
		logic [sut_pkg::RIDX_W-1:0]   read_index;
	} table_cmd_t;

	typedef struct packed {
		logic [sut_pkg::STATUS_W-1:0] status;
		logic [sut_pkg::POS_W-1:0]    position;
		logic [sut_pkg::KEY_W-1:0]    entry_value;
		logic [sut_pkg::POS_W-1:0]    entry_total;
	} table_rsp_t;

	logic                         clk;
	logic                         arst_n;
	logic                         start;
	logic                         busy;
	logic                         opcode;
	logic [sut_pkg::KEY_W-1:0]    key;
	logic [sut_pkg::RIDX_W-1:0]   read_index;
	logic                         done;
	logic [sut_pkg::STATUS_W-1:0] status;
	logic [sut_pkg::POS_W-1:0]    position;
	logic [sut_pkg::KEY_W-1:0]    entry_value;
	logic [sut_pkg::POS_W-1:0]    entry_total;

	sorted_unique_table_insert dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.opcode      (opcode),
		.key         (key),
		.read_index  (read_index),
		.done        (done),
		.status      (status),
		.position    (position),
		.entry_value (entry_value),
		.entry_total (entry_total)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Commands that are still waiting to be driven, and the results that are
	// still waiting to come back from the block.
	table_cmd_t pending_cmds[$];
	table_rsp_t pending_outcomes[$];
	int unsigned fail_count;

	// This is the checker's own copy of the table. It only advances when a
	// transaction is accepted.
	logic [sut_pkg::KEY_W-1:0] table_keys [sut_pkg::DEPTH];
	int unsigned table_count;

	// The stimulus side keeps its own record of which keys end up held. It uses
	// that record to pick found keys and valid read indexes.
	logic [sut_pkg::KEY_W-1:0] stim_held[$];
	bit stim_is_held [logic [sut_pkg::KEY_W-1:0]];

	// These are the driver controls.
	bit drive_on;
	bit took_item;
	int unsigned burst_left;
	int unsigned idle_left;
	table_cmd_t next_cmd;
	table_rsp_t want;

	// This applies one accepted transaction to the table copy and returns the
	// result the block should give. An insert searches only the part of the
	// table below the count. When the key is absent, the larger entries are
	// shifted up and the key goes into the gap. If there is no room, the insert
	// is dropped, but the position the key would have taken is still reported.
	function automatic table_rsp_t run_table_op(input table_cmd_t cmd);
		table_rsp_t rsp;
		logic [sut_pkg::KEY_W-1:0] k;
		int unsigned lo;
		int unsigned hi;
		int unsigned mid;
		int unsigned slot;
		bit hit;
		rsp = '0;
		if (cmd.opcode == sut_pkg::OP_INSERT) begin
			k = cmd.key & sut_pkg::KEY_MASK;
			lo = 0;
			hi = table_count;
			hit = 1'b0;
			slot = 0;
			while (lo < hi && !hit) begin
				mid = lo + (hi - lo) / 2;
				if (table_keys[sut_pkg::IDX_W'(mid)] == k) begin
					hit = 1'b1;
					slot = mid;
				end else if (table_keys[sut_pkg::IDX_W'(mid)] < k) begin
					lo = mid + 1;
				end else begin
					hi = mid;
				end
			end
			if (!hit)
				slot = lo;
			if (hit) begin
				rsp.status = sut_pkg::ST_FOUND;
				rsp.entry_value = k;
			end else if (table_count >= sut_pkg::DEPTH) begin
				rsp.status = sut_pkg::ST_FULL;
			end else begin
				for (int unsigned i = table_count; i > slot; i--)
					table_keys[sut_pkg::IDX_W'(i)] = table_keys[sut_pkg::IDX_W'(i - 1)];
				table_keys[sut_pkg::IDX_W'(slot)] = k;
				table_count++;
				rsp.status = sut_pkg::ST_INSERTED;
				rsp.entry_value = k;
			end
			rsp.position = sut_pkg::POS_W'(slot);
		end else begin
			slot = 32'(cmd.read_index);
			rsp.position = sut_pkg::POS_W'(slot);
			if (slot < table_count) begin
				rsp.status = sut_pkg::ST_READ_OK;
				rsp.entry_value = table_keys[sut_pkg::IDX_W'(slot)];
			end else begin
				rsp.status = sut_pkg::ST_READ_BAD;
			end
		end
		rsp.entry_total = sut_pkg::POS_W'(table_count);
		return rsp;
	endfunction

	task automatic check_field(input string what, input logic [63:0] want_v,
			input logic [63:0] got_v);
		if (got_v !== want_v) begin
			fail_count++;
			$display("%0t ns: %s mismatch, expected %0h, actual %0h",
				$time, what, want_v, got_v);
		end
	endtask

	task automatic queue_insert(input logic [sut_pkg::KEY_W-1:0] k);
		table_cmd_t c;
		logic [sut_pkg::KEY_W-1:0] m;
		c.opcode = sut_pkg::OP_INSERT;
		c.key = k;
		c.read_index = sut_pkg::RIDX_W'($urandom);
		pending_cmds.push_back(c);
		m = k & sut_pkg::KEY_MASK;
		if (!stim_is_held.exists(m) && stim_held.size() < sut_pkg::DEPTH) begin
			stim_is_held[m] = 1'b1;
			stim_held.push_back(m);
		end
	endtask

	task automatic queue_read(input int unsigned idx);
		table_cmd_t c;
		c.opcode = sut_pkg::OP_READ;
		c.key = {$urandom, $urandom};
		c.read_index = sut_pkg::RIDX_W'(idx);
		pending_cmds.push_back(c);
	endtask

	// Fresh keys come in three kinds. Wide random keys spread across the whole
	// range. Small keys collide often and produce found results. Keys shifted
	// down by a random amount cover every magnitude in between.
	function automatic logic [sut_pkg::KEY_W-1:0] fresh_key();
		int unsigned kind;
		kind = $urandom_range(0, 9);
		if (kind < 6)
			return {$urandom, $urandom};
		else if (kind < 8)
			return 64'($urandom_range(0, 1023));
		else
			return {$urandom, $urandom} >> $urandom_range(0, 63);
	endfunction

	function automatic logic [sut_pkg::KEY_W-1:0] held_key();
		return stim_held[$urandom_range(0, stim_held.size() - 1)];
	endfunction

	// The driver changes the inputs on the falling edge. A new command goes out
	// once the previous one was taken or start is low, and no idle gap is
	// pending. While it idles, the command fields carry random values.
	always @(negedge clk) begin
		if (drive_on && (!start || took_item)) begin
			if (idle_left > 0 || pending_cmds.size() == 0) begin
				if (idle_left > 0)
					idle_left--;
				start <= 1'b0;
				opcode <= 1'($urandom);
				key <= {$urandom, $urandom};
				read_index <= sut_pkg::RIDX_W'($urandom);
			end else begin
				next_cmd = pending_cmds.pop_front();
				start <= 1'b1;
				opcode <= next_cmd.opcode;
				key <= next_cmd.key;
				read_index <= next_cmd.read_index;
				burst_left--;
				if (burst_left == 0) begin
					// Some bursts run straight into the next one with no gap.
					burst_left = $urandom_range(1, 24);
					idle_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end
			end
		end
	end

	// On the rising edge, a done strobe is checked first. After that, a
	// transaction accepted at the same edge is applied to the table copy. The
	// two can only meet when busy drops in the cycle of a result, and that
	// result always belongs to the earlier transaction.
	always @(posedge clk) begin
		if (arst_n && done !== 1'b0) begin
			if (pending_outcomes.size() == 0) begin
				fail_count++;
				$display("%0t ns: result with no transaction waiting, expected none, actual status %0h",
					$time, status);
			end else begin
				want = pending_outcomes.pop_front();
				check_field("status", want.status, status);
				check_field("position", want.position, position);
				check_field("entry_value", want.entry_value, entry_value);
				check_field("entry_total", want.entry_total, entry_total);
			end
		end
		if (arst_n && start && busy === 1'b0)
			pending_outcomes.push_back(run_table_op(table_cmd_t'({opcode, key, read_index})));
		took_item <= arst_n && start && busy === 1'b0;
	end

	initial begin
		int unsigned pick;
		arst_n = 1'b0;
		start = 1'b0;
		opcode = sut_pkg::OP_INSERT;
		key = '0;
		read_index = '0;
		drive_on = 1'b0;
		took_item = 1'b0;
		fail_count = 0;
		table_count = 0;
		burst_left = $urandom_range(1, 24);
		idle_left = 0;

		// The directed opening starts with reads on the empty table. Then come
		// key zero and the key extremes. Each of those keys is inserted and
		// then inserted again to find it.
		queue_read(0);
		queue_read(4095);
		queue_insert('0);
		queue_insert('0);
		queue_insert(64'hFFFF_FFFF_FFFF_FFFE);
		queue_insert(64'hFFFF_FFFF_FFFF_FFFE);
		queue_insert(64'd1);
		queue_insert(64'h8000_0000_0000_0000);
		queue_insert(64'h7FFF_FFFF_FFFF_FFFF);
		queue_insert(64'd2);
		for (int i = 0; i < 6; i++)
			queue_read(i);
		// The count is six at this point. A read at the count and a read at
		// the top index both fall beyond it.
		queue_read(6);
		queue_read(4095);
		queue_insert(64'h8000_0000_0000_0000);
		queue_insert('0);
		queue_read(0);

		// The random middle mixes misses, hits, near misses and reads. Reads are
		// both inside and beyond the count.
		for (int n = 0; n < 1000; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 40)
				queue_insert(fresh_key());
			else if (pick < 60)
				queue_insert(held_key());
			else if (pick < 65)
				queue_insert(held_key() + 64'd1);
			else if (pick < 70)
				queue_insert(held_key() - 64'd1);
			else if (pick < 90)
				queue_read($urandom_range(0, stim_held.size() - 1));
			else
				queue_read($urandom_range(0, 4095));
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);
		drive_on = 1'b1;

		// Drain everything that is queued, then let the block sit for longer
		// than its slowest insert, so that any stray result still shows up.
		while (pending_cmds.size() != 0 || start)
			@(posedge clk);
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);

		if (fail_count == 0 && pending_outcomes.size() == 0) begin
			$display("sorted_unique_table_insert verification clean");
		end else begin
			$display("sorted_unique_table_insert verification failed");
		end
		$finish;
	end

	// An insert of an absent key is the slowest transaction, so about a
	// thousand transactions need well under seven million ns even when every
	// one is such an insert behind the longest idle gap. This limit is several
	// times that.
	initial begin
		#40_000_000;
		$display("sorted_unique_table_insert verification failed");
		$finish;
	end

endmodule
